// ----- src/tnbd_pkg.sv -----
// ----------------------------------------------------------------------------
// tnbd_pkg
// shared types, widths and helpers for the table network block decryptor
// ----------------------------------------------------------------------------
package tnbd_pkg;

    // fixed field widths
    localparam int ADDR_W = 15;
    localparam int WORD_W = 64;
    localparam int BYTE_W = 8;
    localparam int NBYTES = 16;
    localparam int BANKS  = 16;

    // round counter covers every supported round count (up to 14)
    localparam int RND_W = 4;
    // table row quotient: four tables per bank per round, {round, column}
    localparam int TQ_W  = RND_W + 2;
    // full bank row before trimming to the bank depth
    localparam int ROWF_W = TQ_W + 5;

    typedef logic [NBYTES-1:0][BYTE_W-1:0] t_state;

    // controller to datapath commands
    typedef struct packed {
        logic             load_blk;   // take a new ciphertext block
        logic             wr_en;      // table load word
        logic             rd_en;      // issue bank reads
        logic             rd_last;    // final round lookups
        logic [1:0]       rd_col;     // column being read
        logic             cap_en;     // capture one column of lookups
        logic [1:0]       cap_col;    // column being captured
        logic             cap_shift;  // last column: refresh state with row shift
        logic             cap_final;  // capture final round bytes
        logic             push_out;   // move result into the output register
        logic [RND_W-1:0] round;      // network round index
    } t_dp_cmd;

    // inverse aes row shift on a column-major 16-byte state
    function automatic t_state inv_shift(input t_state s);
        t_state o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[4*c + r] = s[4*((c + 4 - r) % 4) + r];
            end
        end
        return o;
    endfunction

endpackage

// ----- src/tnbd_if.sv -----
// ----------------------------------------------------------------------------
// tnbd channel interfaces
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface tnbd_in_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [tnbd_pkg::ADDR_W-1:0] table_word_addr;
    logic [tnbd_pkg::WORD_W-1:0] table_word;
    logic [tnbd_pkg::WORD_W-1:0] block_hi;
    logic [tnbd_pkg::WORD_W-1:0] block_lo;

    modport source (
        output valid, req_type, table_word_addr, table_word, block_hi, block_lo,
        input  ready
    );
    modport sink (
        input  valid, req_type, table_word_addr, table_word, block_hi, block_lo,
        output ready
    );
endinterface

interface tnbd_out_if;
    logic                        valid;
    logic                        ready;
    logic [tnbd_pkg::WORD_W-1:0] plain_hi;
    logic [tnbd_pkg::WORD_W-1:0] plain_lo;

    modport source (output valid, plain_hi, plain_lo, input ready);
    modport sink   (input valid, plain_hi, plain_lo, output ready);
endinterface

// ----- src/tnbd_dp.sv -----
// ----------------------------------------------------------------------------
// tnbd_dp
// sixteen table banks, round state, column xor and output register
// ----------------------------------------------------------------------------
module tnbd_dp #(
    parameter int ROUNDS = 10
) (
    input  logic                        i_clk,
    input  tnbd_pkg::t_dp_cmd           i_cmd,
    input  logic [tnbd_pkg::ADDR_W-1:0] i_table_word_addr,
    input  logic [tnbd_pkg::WORD_W-1:0] i_table_word,
    input  logic [tnbd_pkg::WORD_W-1:0] i_block_hi,
    input  logic [tnbd_pkg::WORD_W-1:0] i_block_lo,
    output logic [tnbd_pkg::WORD_W-1:0] o_plain_hi,
    output logic [tnbd_pkg::WORD_W-1:0] o_plain_lo
);
    import tnbd_pkg::*;

    localparam int TABLE_COUNT = 64 * (ROUNDS - 1) + 16;
    localparam int BANK_DEPTH  = (TABLE_COUNT / BANKS) * 32;
    localparam int ROW_W       = $clog2(BANK_DEPTH);
    localparam int STORE_WORDS = TABLE_COUNT * 32;
    localparam logic [ADDR_W-1:0] WORD_LIMIT = ADDR_W'(STORE_WORDS);
    localparam logic [TQ_W-1:0]   TQ_LAST    = TQ_W'(4 * (ROUNDS - 1));

    t_state r_s;
    t_state r_t;
    t_state n_t;
    t_state w_blk;
    t_state w_lk;
    t_state r_plain;

    logic [WORD_W-1:0] r_rd  [BANKS];
    logic [2:0]        r_sel [BANKS];
    logic [BYTE_W-1:0] w_col [4];

    // load word: table = addr / 32, bank = table % 16
    logic              w_wr_ok;
    logic [3:0]        w_wr_bank;
    logic [ROWF_W-1:0] w_wr_rowf;

    assign w_wr_ok   = i_cmd.wr_en && (i_table_word_addr < WORD_LIMIT);
    assign w_wr_bank = i_table_word_addr[8:5];
    assign w_wr_rowf = {i_table_word_addr[14:9], i_table_word_addr[4:0]};

    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        logic [WORD_W-1:0] mem [BANK_DEPTH];
        logic [BYTE_W-1:0] w_idx;
        logic [TQ_W-1:0]   w_tq;
        logic [ROWF_W-1:0] w_rowf;

        assign w_idx  = i_cmd.rd_last ? r_s[b] : r_s[{i_cmd.rd_col, 2'(b / 4)}];
        assign w_tq   = i_cmd.rd_last ? TQ_LAST : {i_cmd.round, i_cmd.rd_col};
        assign w_rowf = {w_tq, w_idx[7:3]};

        always_ff @(posedge i_clk) begin
            if (w_wr_ok && (w_wr_bank == 4'(b))) begin
                mem[w_wr_rowf[ROW_W-1:0]] <= i_table_word;
            end
            if (i_cmd.rd_en) begin
                r_rd[b]  <= mem[w_rowf[ROW_W-1:0]];
                r_sel[b] <= w_idx[2:0];
            end
        end

        // lowest entry sits in the top byte
        assign w_lk[b] = r_rd[b][{~r_sel[b], 3'b000} +: BYTE_W];
    end

    // column byte r is the xor of banks r, 4+r, 8+r, 12+r
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            w_col[r] = w_lk[r] ^ w_lk[4 + r] ^ w_lk[8 + r] ^ w_lk[12 + r];
        end
        n_t = r_t;
        for (int r = 0; r < 4; r++) begin
            n_t[{i_cmd.cap_col, 2'(r)}] = w_col[r];
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_blk[i]     = i_block_hi[WORD_W-1-8*i -: BYTE_W];
            w_blk[8 + i] = i_block_lo[WORD_W-1-8*i -: BYTE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_blk) begin
            r_s <= inv_shift(w_blk);
        end else if (i_cmd.cap_shift) begin
            r_s <= inv_shift(n_t);
        end
        if (i_cmd.cap_final) begin
            r_t <= w_lk;
        end else if (i_cmd.cap_en) begin
            r_t <= n_t;
        end
        if (i_cmd.push_out) begin
            r_plain <= r_t;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_plain_hi[WORD_W-1-8*i -: BYTE_W] = r_plain[i];
            o_plain_lo[WORD_W-1-8*i -: BYTE_W] = r_plain[8 + i];
        end
    end

endmodule

// ----- src/tnbd_ctrl.sv -----
// ----------------------------------------------------------------------------
// tnbd_ctrl
// sequencer for loads, network rounds, final round and result hand-off
// ----------------------------------------------------------------------------
module tnbd_ctrl #(
    parameter int ROUNDS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_req_type,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tnbd_pkg::t_dp_cmd o_cmd
);
    import tnbd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROUND = 3'd1;
    localparam logic [2:0] S_LAST  = 3'd2;
    localparam logic [2:0] S_LWAIT = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam logic       REQ_LOAD    = 1'b0;
    localparam logic       REQ_DECRYPT = 1'b1;
    localparam logic [2:0] COL_DRAIN   = 3'd4;
    localparam logic [RND_W-1:0] LAST_NET = RND_W'(ROUNDS - 2);

    logic [2:0]       r_state, n_state;
    logic [2:0]       r_col, n_col;
    logic [RND_W-1:0] r_round, n_round;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_round = r_round;
        o_cmd   = '0;
        o_cmd.round   = r_round;
        o_cmd.rd_col  = r_col[1:0];
        o_cmd.cap_col = 2'(r_col - 3'd1);

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == REQ_LOAD) begin
                        o_cmd.wr_en = 1'b1;
                    end else begin
                        o_cmd.load_blk = 1'b1;
                        n_round = '0;
                        n_col   = '0;
                        n_state = S_ROUND;
                    end
                end
            end
            S_ROUND: begin
                o_cmd.rd_en     = (r_col != COL_DRAIN);
                o_cmd.cap_en    = (r_col != 3'd0);
                o_cmd.cap_shift = (r_col == COL_DRAIN);
                if (r_col == COL_DRAIN) begin
                    n_col = '0;
                    if (r_round == LAST_NET) begin
                        n_state = S_LAST;
                    end else begin
                        n_round = r_round + 1'b1;
                    end
                end else begin
                    n_col = r_col + 3'd1;
                end
            end
            S_LAST: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_last = 1'b1;
                n_state = S_LWAIT;
            end
            S_LWAIT: begin
                o_cmd.cap_final = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.push_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        if (o_cmd.push_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    // result never overwrites a word that is still waiting
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push_out |-> (!r_out_valid || i_out_ready))
        else $error("result pushed over a pending word");

    // column counter stays within read plus drain steps
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_col <= COL_DRAIN))
        else $error("column counter out of range");

    // network round index never passes the last network round
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_round <= LAST_NET))
        else $error("round counter out of range");

    // a decrypt starts at round zero, column zero
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req_type == REQ_DECRYPT)
        |=> (r_state == S_ROUND && r_round == '0 && r_col == '0))
        else $error("decrypt did not start at round zero");

    // final lookups are captured in the cycle after they are issued
    a_last_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAST) |=> (r_state == S_LWAIT))
        else $error("final round capture out of step");

endmodule

// ----- src/table_network_block_decrypt_core.sv -----
// ----------------------------------------------------------------------------
// table_network_block_decrypt_core
// table network block decryptor (white-box style aes-128 decryption)
// ----------------------------------------------------------------------------
// Each request word is a table load (req_type 0) or a block decrypt
// (req_type 1). A load writes eight bytes into the lookup table store
// and returns nothing; word indexes past the store are dropped. A decrypt
// returns one 128-bit result word. The store holds 64*(ROUNDS-1)+16
// tables of 256 bytes split over sixteen banks by table index mod 16, so
// each network round reads its four columns in turn and then drains the
// last column: a decrypt occupies the block from acceptance until its
// result moves into the output register, bounded by the one read port per
// bank, while a load leaves the block ready for the next word. The
// finished result sits in an output register, so new words, loads or
// decrypts, are accepted while it waits to be taken. Tables must be loaded
// before they are read; the store has no reset value.
// ----------------------------------------------------------------------------
module table_network_block_decrypt_core #(
    parameter int ROUNDS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tnbd_in_if.sink           i_in,
    tnbd_out_if.source        o_out
);
    import tnbd_pkg::*;

    t_dp_cmd w_cmd;
    logic    w_in_ready;
    logic    w_out_valid;

    // sequencer: accepts words, steps through columns and rounds
    tnbd_ctrl #(
        .ROUNDS (ROUNDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_req_type  (i_in.req_type),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    // table banks, round state and output register
    tnbd_dp #(
        .ROUNDS (ROUNDS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_cmd             (w_cmd),
        .i_table_word_addr (i_in.table_word_addr),
        .i_table_word      (i_in.table_word),
        .i_block_hi        (i_in.block_hi),
        .i_block_lo        (i_in.block_lo),
        .o_plain_hi        (o_out.plain_hi),
        .o_plain_lo        (o_out.plain_lo)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

endmodule

// ----- tb/table_network_block_decrypt_core_tb.sv -----
// ----------------------------------------------------------------------------
// table_network_block_decrypt_core_tb
// self-checking bench for the table network block decryptor: fills the whole
// lookup table store, then runs directed and random loads and decrypts with
// random idling on both channels and compares every result word against an
// in-bench model of the table network
// ----------------------------------------------------------------------------
module table_network_block_decrypt_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // block geometry at the default round count
    localparam int ROUNDS      = 10;
    localparam int TABLES      = 64 * (ROUNDS - 1) + 16;
    localparam int STORE_BYTES = TABLES * 256;
    localparam int STORE_WORDS = STORE_BYTES / 8;
    localparam int ADDR_MAX    = (1 << tnbd_pkg::ADDR_W) - 1;

    // request kinds
    localparam bit REQ_LOAD    = 1'b0;
    localparam bit REQ_DECRYPT = 1'b1;

    // run shaping
    localparam int RAND_WORDS   = 1450;
    localparam int QUIET_FROM   = 300;    // no idling on either side in here
    localparam int QUIET_TO     = 600;
    localparam int DRAIN_AT     = 900;    // sender waits for every result here
    localparam int HOLD_AT      = 150;    // result count that starts the long hold
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_PCT     = 38;
    localparam int TAIL_CYCLES  = 80;
    localparam int LIMIT_NS     = 2_000_000;

    typedef logic [tnbd_pkg::WORD_W-1:0] word_t;

    typedef struct packed {
        word_t hi;
        word_t lo;
    } plain_t;

    // ------------------------------------------------------------------------
    // table network model and result bookkeeping
    // ------------------------------------------------------------------------
    class plain_tracker;
        bit [7:0]    lut [STORE_BYTES];
        plain_t      plain_due [$];
        int unsigned failures;
        int unsigned taken;

        // one table network pass over a 16-byte block
        function plain_t decipher_block(word_t hi, word_t lo);
            bit [7:0] st [16];
            bit [7:0] sh [16];
            bit [7:0] mix;
            plain_t   res;
            for (int i = 0; i < 8; i++) begin
                st[i]     = hi[63-8*i -: 8];
                st[8 + i] = lo[63-8*i -: 8];
            end
            for (int rnd = 0; rnd < ROUNDS; rnd++) begin
                // inverse row shift, column-major state
                for (int c = 0; c < 4; c++) begin
                    for (int r = 0; r < 4; r++) begin
                        sh[4*c + r] = st[4*((c + 4 - r) % 4) + r];
                    end
                end
                if (rnd == ROUNDS - 1) begin
                    for (int i = 0; i < 16; i++) begin
                        st[i] = lut[(64*rnd + i)*256 + sh[i]];
                    end
                end else begin
                    for (int c = 0; c < 4; c++) begin
                        for (int r = 0; r < 4; r++) begin
                            mix = 8'h00;
                            for (int k = 0; k < 4; k++) begin
                                mix ^= lut[(64*rnd + 16*c + 4*k + r)*256 + sh[4*c + k]];
                            end
                            st[4*c + r] = mix;
                        end
                    end
                end
            end
            for (int i = 0; i < 8; i++) begin
                res.hi[63-8*i -: 8] = st[i];
                res.lo[63-8*i -: 8] = st[8 + i];
            end
            return res;
        endfunction

        // an accepted request word
        function void note_word(bit kind, logic [tnbd_pkg::ADDR_W-1:0] addr,
                                word_t tw, word_t bhi, word_t blo);
            if (kind == REQ_LOAD) begin
                // words past the store are dropped
                if (addr < STORE_WORDS) begin
                    for (int i = 0; i < 8; i++) begin
                        lut[addr*8 + i] = tw[63-8*i -: 8];
                    end
                end
            end else begin
                plain_due.push_back(decipher_block(bhi, blo));
            end
        endfunction

        // an accepted result word
        function void check_plain(word_t hi, word_t lo);
            plain_t want;
            taken++;
            if (plain_due.size() == 0) begin
                failures++;
                $display("%0t unexpected result: expected none, actual %h %h",
                         $time, hi, lo);
                return;
            end
            want = plain_due.pop_front();
            if (hi !== want.hi) begin
                failures++;
                $display("%0t plain_hi mismatch: expected %h, actual %h",
                         $time, want.hi, hi);
            end
            if (lo !== want.lo) begin
                failures++;
                $display("%0t plain_lo mismatch: expected %h, actual %h",
                         $time, want.lo, lo);
            end
        endfunction

        function int pending();
            return plain_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels, block
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    tnbd_in_if  in_if ();
    tnbd_out_if out_if ();

    table_network_block_decrypt_core #(
        .ROUNDS (ROUNDS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    plain_tracker sb = new;

    // both sides stop idling while this is set
    bit quiet = 1'b0;

    function automatic word_t rand64();
        return {$urandom, $urandom};
    endfunction

    // offer one request word and hold it until taken, then maybe idle
    task automatic send_word(bit kind, logic [tnbd_pkg::ADDR_W-1:0] addr,
                             word_t tw, word_t bhi, word_t blo);
        int gap;
        in_if.valid           <= 1'b1;
        in_if.req_type        <= kind;
        in_if.table_word_addr <= addr;
        in_if.table_word      <= tw;
        in_if.block_hi        <= bhi;
        in_if.block_lo        <= blo;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_word(kind, addr, tw, bhi, blo);
        // idle cycles drawn one at a time, so gaps land anywhere in a decrypt
        gap = 0;
        while (!quiet && $urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_load(logic [tnbd_pkg::ADDR_W-1:0] addr, word_t tw);
        // block fields carry junk, the block must ignore them on a load
        send_word(REQ_LOAD, addr, tw, rand64(), rand64());
    endtask

    task automatic send_decrypt(word_t bhi, word_t blo);
        // table fields carry junk, the block must ignore them on a decrypt
        send_word(REQ_DECRYPT, tnbd_pkg::ADDR_W'($urandom), rand64(), bhi, blo);
    endtask

    // ------------------------------------------------------------------------
    // reset: held low at start, released once
    // ------------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // result side: random stalls, one long hold once the block is busy
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned hold_left;
        bit          held;
        hold_left = 0;
        held      = 1'b0;
        out_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                sb.check_plain(out_if.plain_hi, out_if.plain_lo);
            end
            // long hold so the output register fills and the input backs up
            if (!held && sb.taken == HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (quiet) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    initial begin : request_source
        bit                          kind;
        logic [tnbd_pkg::ADDR_W-1:0] addr;

        in_if.valid           <= 1'b0;
        in_if.req_type        <= REQ_LOAD;
        in_if.table_word_addr <= '0;
        in_if.table_word      <= '0;
        in_if.block_hi        <= '0;
        in_if.block_lo        <= '0;
        while (!i_rst_n) @(posedge i_clk);

        // fill every table so no decrypt can touch an unwritten entry
        for (int w = 0; w < STORE_WORDS; w++) begin
            send_load(tnbd_pkg::ADDR_W'(w), rand64());
        end

        // directed: loads past the store are dropped, so results must not move
        send_load(tnbd_pkg::ADDR_W'(ADDR_MAX), '1);
        send_load(tnbd_pkg::ADDR_W'(STORE_WORDS), 64'hA5A5_5A5A_F00F_0FF0);
        send_decrypt('0, '0);
        send_decrypt('1, '1);
        send_decrypt(64'h0001_0203_0405_0607, 64'h0809_0A0B_0C0D_0E0F);
        send_decrypt(64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE);
        // first and last word of the store, all-ones and all-zeros data
        send_load('0, '1);
        send_load(tnbd_pkg::ADDR_W'(STORE_WORDS - 1), '0);
        send_decrypt('0, '0);
        send_decrypt('1, '1);
        send_load('0, '0);
        send_load(tnbd_pkg::ADDR_W'(STORE_WORDS - 1), '1);
        send_decrypt('0, '0);
        send_decrypt('1, '1);
        send_load(tnbd_pkg::ADDR_W'(STORE_WORDS), '1);
        send_decrypt(64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF);

        // random mix: mostly decrypts, loads overwrite tables at random
        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n == QUIET_FROM) quiet <= 1'b1;
            if (n == QUIET_TO)   quiet <= 1'b0;
            if (n == DRAIN_AT) begin
                // let the block run dry before going on
                in_if.valid <= 1'b0;
                do @(posedge i_clk); while (sb.pending() != 0);
            end
            kind = ($urandom_range(99) < 60) ? REQ_DECRYPT : REQ_LOAD;
            if (kind == REQ_DECRYPT) begin
                send_decrypt(rand64(), rand64());
            end else begin
                if ($urandom_range(99) < 85) begin
                    addr = tnbd_pkg::ADDR_W'($urandom_range(STORE_WORDS - 1));
                end else begin
                    addr = tnbd_pkg::ADDR_W'($urandom_range(ADDR_MAX, STORE_WORDS));
                end
                send_load(addr, rand64());
            end
        end
        in_if.valid <= 1'b0;

        // wait for the last results, then watch for strays
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
